// ===== design/tle_pkg.sv =====
// Shared constants, types and the microcode table for the terminal line editor.
package tle_pkg;

    // Line geometry.
    localparam int LINE_LENGTH = 40;
    localparam int CUR_W = 6;
    localparam int BYTE_W = 8;

    // Keystroke codes.
    localparam logic [BYTE_W-1:0] KEY_ERASE = 8'd127;
    localparam logic [BYTE_W-1:0] KEY_KILL = 8'd21;
    localparam logic [BYTE_W-1:0] KEY_WORD = 8'd23;
    localparam logic [BYTE_W-1:0] KEY_EOF = 8'd4;
    localparam logic [BYTE_W-1:0] KEY_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] PRINT_LOW = 8'd32;
    localparam logic [BYTE_W-1:0] PRINT_HIGH = 8'd126;

    // Display action codes carried on the result word.
    typedef enum logic [2:0] {
        ACT_ECHO = 3'd0,
        ACT_ERASE = 3'd1,
        ACT_BELL = 3'd2,
        ACT_NEWLINE = 3'd3,
        ACT_EOF = 3'd4
    } act_t;

    // Cursor and line store operation of a step.
    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_DEC,
        CUR_INC_WRITE
    } cur_op_t;

    // Which stored character the line store read port fetches.
    typedef enum logic {
        RD_M1,
        RD_M2
    } rd_sel_t;

    // Branch conditions tested by a step.
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_AT_ONE,
        COND_LINE_END,
        COND_RD_SPACE,
        COND_WORD_END
    } cond_t;

    // Step addresses of the microprogram.
    typedef logic [3:0] step_t;
    localparam step_t S_IDLE = 4'd0;
    localparam step_t S_EOF = 4'd1;
    localparam step_t S_BELL = 4'd2;
    localparam step_t S_ERASE = 4'd3;
    localparam step_t S_ECHO = 4'd4;
    localparam step_t S_NL = 4'd5;
    localparam step_t S_KILL = 4'd6;
    localparam step_t S_WS_WAIT = 4'd7;
    localparam step_t S_WS_TEST = 4'd8;
    localparam step_t S_WS_DEL = 4'd9;
    localparam step_t S_WN_PRE = 4'd10;
    localparam step_t S_WN_DEL = 4'd11;

    // One control word of the microprogram.
    typedef struct packed {
        logic emit;
        act_t act;
        cur_op_t cur_op;
        rd_sel_t rd_sel;
        cond_t cond;
        step_t tgt_t;
        step_t tgt_f;
    } ctrl_t;

    // Datapath status seen by the sequencer.
    typedef struct packed {
        logic cursor_zero;
        logic at_one;
        logic line_end;
        logic rd_space;
        logic out_free;
    } status_t;

    // Microcode table: one control word per step.
    function automatic ctrl_t ucode(step_t pc);
        ctrl_t w;
        unique case (pc)
            S_EOF:
                w = '{1'b1, ACT_EOF, CUR_HOLD, RD_M1, COND_ALWAYS, S_IDLE, S_IDLE};
            S_BELL:
                w = '{1'b1, ACT_BELL, CUR_HOLD, RD_M1, COND_ALWAYS, S_IDLE, S_IDLE};
            S_ERASE:
                w = '{1'b1, ACT_ERASE, CUR_DEC, RD_M1, COND_ALWAYS, S_IDLE, S_IDLE};
            S_ECHO:
                w = '{1'b1, ACT_ECHO, CUR_INC_WRITE, RD_M1, COND_LINE_END, S_NL, S_IDLE};
            S_NL:
                w = '{1'b1, ACT_NEWLINE, CUR_HOLD, RD_M1, COND_ALWAYS, S_IDLE, S_IDLE};
            S_KILL:
                w = '{1'b1, ACT_ERASE, CUR_DEC, RD_M1, COND_AT_ONE, S_IDLE, S_KILL};
            S_WS_WAIT:
                w = '{1'b0, ACT_ECHO, CUR_HOLD, RD_M1, COND_ALWAYS, S_WS_TEST, S_WS_TEST};
            S_WS_TEST:
                w = '{1'b0, ACT_ECHO, CUR_HOLD, RD_M1, COND_RD_SPACE, S_WS_DEL, S_WN_PRE};
            S_WS_DEL:
                w = '{1'b1, ACT_ERASE, CUR_DEC, RD_M1, COND_AT_ONE, S_IDLE, S_WS_WAIT};
            S_WN_PRE:
                w = '{1'b0, ACT_ECHO, CUR_HOLD, RD_M2, COND_ALWAYS, S_WN_DEL, S_WN_DEL};
            S_WN_DEL:
                w = '{1'b1, ACT_ERASE, CUR_DEC, RD_M2, COND_WORD_END, S_IDLE, S_WN_PRE};
            default:
                w = '{1'b0, ACT_ECHO, CUR_HOLD, RD_M1, COND_ALWAYS, S_IDLE, S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== design/tle_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40,
    parameter int AW = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/tle_sequencer.sv =====
// Microcode sequencer: step counter, keystroke dispatch and conditional branches.
module tle_sequencer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [tle_pkg::BYTE_W-1:0]   key_byte,
    input  tle_pkg::status_t             st,
    output logic                         in_ready,
    output tle_pkg::ctrl_t               ctrl,
    output logic                         adv,
    output logic                         last
);

    tle_pkg::step_t pc_reg;
    tle_pkg::step_t pc_next;
    tle_pkg::step_t branch;
    tle_pkg::step_t entry;
    logic cond_true;

    // Current control word.
    assign ctrl = tle_pkg::ucode(pc_reg);

    // Branch condition select.
    always_comb
    begin
        unique case (ctrl.cond)
            tle_pkg::COND_ALWAYS:   cond_true = 1'b1;
            tle_pkg::COND_AT_ONE:   cond_true = st.at_one;
            tle_pkg::COND_LINE_END: cond_true = st.line_end;
            tle_pkg::COND_RD_SPACE: cond_true = st.rd_space;
            tle_pkg::COND_WORD_END: cond_true = st.at_one || st.rd_space;
            default:                cond_true = 1'b1;
        endcase
    end

    assign branch = cond_true ? ctrl.tgt_t : ctrl.tgt_f;

    // A step that emits waits until the output register can take the word.
    assign adv = !ctrl.emit || st.out_free;
    assign last = (branch == tle_pkg::S_IDLE);
    assign in_ready = (pc_reg == tle_pkg::S_IDLE);

    // Entry step chosen from the keystroke.
    always_comb
    begin
        priority if (key_byte == tle_pkg::KEY_EOF && st.cursor_zero)
            entry = tle_pkg::S_EOF;
        else if (key_byte == tle_pkg::KEY_ERASE)
            entry = st.cursor_zero ? tle_pkg::S_BELL : tle_pkg::S_ERASE;
        else if (key_byte == tle_pkg::KEY_KILL)
            entry = st.cursor_zero ? tle_pkg::S_IDLE : tle_pkg::S_KILL;
        else if (key_byte == tle_pkg::KEY_WORD)
            entry = st.cursor_zero ? tle_pkg::S_IDLE : tle_pkg::S_WS_WAIT;
        else if (key_byte >= tle_pkg::PRINT_LOW && key_byte <= tle_pkg::PRINT_HIGH)
            entry = tle_pkg::S_ECHO;
        else
            entry = tle_pkg::S_BELL;
    end

    // Next step.
    always_comb
    begin
        if (pc_reg == tle_pkg::S_IDLE)
        begin
            pc_next = in_valid ? entry : tle_pkg::S_IDLE;
        end
        else
        begin
            pc_next = adv ? branch : pc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= tle_pkg::S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== design/tle_datapath.sv =====
// Datapath: cursor, keystroke register, line store and output word register.
module tle_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [tle_pkg::BYTE_W-1:0]   key_byte,
    input  tle_pkg::ctrl_t               ctrl,
    input  logic                         adv,
    input  logic                         last,
    input  logic                         out_ready,
    output tle_pkg::status_t             st,
    output logic                         out_valid,
    output logic [2:0]                   action,
    output logic [tle_pkg::BYTE_W-1:0]   echo_byte,
    output logic                         last_of_run
);

    localparam logic [tle_pkg::CUR_W-1:0] CUR_LAST =
        tle_pkg::CUR_W'(tle_pkg::LINE_LENGTH - 1);

    logic [tle_pkg::CUR_W-1:0] cursor_reg;
    logic [tle_pkg::CUR_W-1:0] cursor_next;
    logic [tle_pkg::BYTE_W-1:0] key_reg;
    logic out_valid_reg;
    logic out_valid_next;
    tle_pkg::act_t act_reg;
    logic [tle_pkg::BYTE_W-1:0] echo_reg;
    logic last_reg;
    logic load_out;
    logic ram_we;
    logic [tle_pkg::CUR_W-1:0] raddr;
    logic [tle_pkg::BYTE_W-1:0] rdata;

    // Status toward the sequencer.
    assign st.cursor_zero = (cursor_reg == '0);
    assign st.at_one = (cursor_reg == tle_pkg::CUR_W'(1));
    assign st.line_end = (cursor_reg == CUR_LAST);
    assign st.rd_space = (rdata == tle_pkg::KEY_SPACE);
    assign st.out_free = !out_valid_reg || out_ready;

    // Cursor update; it wraps to zero as the line fills.
    always_comb
    begin
        cursor_next = cursor_reg;
        if (adv)
        begin
            unique case (ctrl.cur_op)
                tle_pkg::CUR_HOLD:      cursor_next = cursor_reg;
                tle_pkg::CUR_DEC:       cursor_next = cursor_reg - tle_pkg::CUR_W'(1);
                tle_pkg::CUR_INC_WRITE: cursor_next = st.line_end ? '0 :
                                                      cursor_reg + tle_pkg::CUR_W'(1);
                default:                cursor_next = cursor_reg;
            endcase
        end
    end

    // Line store access: write at the cursor, read one or two places behind it.
    assign ram_we = adv && (ctrl.cur_op == tle_pkg::CUR_INC_WRITE);
    assign raddr = (ctrl.rd_sel == tle_pkg::RD_M2) ? cursor_reg - tle_pkg::CUR_W'(2) :
                                                     cursor_reg - tle_pkg::CUR_W'(1);

    tle_ram #(
        .WIDTH(tle_pkg::BYTE_W),
        .DEPTH(tle_pkg::LINE_LENGTH),
        .AW(tle_pkg::CUR_W)
    ) u_store (
        .clk(clk),
        .we(ram_we),
        .waddr(cursor_reg),
        .wdata(key_reg),
        .raddr(raddr),
        .rdata(rdata)
    );

    // Output word register.
    assign load_out = ctrl.emit && adv;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= key_byte;
        end
        if (load_out)
        begin
            act_reg <= ctrl.act;
            echo_reg <= (ctrl.act == tle_pkg::ACT_ECHO) ? key_reg : '0;
            last_reg <= last;
        end
    end

    assign out_valid = out_valid_reg;
    assign action = act_reg;
    assign echo_byte = echo_reg;
    assign last_of_run = last_reg;

`ifndef NO_ASSERTIONS
    // The cursor never reaches the line length.
    assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg < tle_pkg::CUR_W'(tle_pkg::LINE_LENGTH))
        else $error("cursor out of range");

    // No character is removed at column zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && ctrl.cur_op == tle_pkg::CUR_DEC) |-> !st.cursor_zero)
        else $error("erase at column zero");

    // A word that is not an echo carries a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && act_reg != tle_pkg::ACT_ECHO) |-> echo_reg == '0)
        else $error("nonzero byte on non-echo word");

    // A stalled output word is not overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !load_out)
        else $error("output word overwritten");
`endif

endmodule

// ===== design/terminal_line_editor_unit.sv =====
// Top level of the terminal line editor.
//
// Keystroke bytes enter on in_valid/in_ready with key_byte; display words
// leave on out_valid/out_ready with action, echo_byte and last_of_run.
// A keystroke may cause no word (kill or word erase at column 0), one word,
// two (echo then newline when the line fills) or a run of erase words.
// The last word of a keystroke carries last_of_run.
// in_ready is high only while the microcode sequencer is idle. The first
// word of a keystroke is loaded into the output register by the entry
// step, or for word erase by the first delete step. Kill gives one erase
// word per cycle unless the receiver stalls. Word erase runs the wait,
// test and delete steps per trailing space, the wait and test steps for
// the first word character and the pre and delete steps per word character,
// since each test waits on the registered read of the line store. Echo,
// bell, erase and end of input take one step; echo with newline runs the
// echo step, then the newline step. When the receiver stalls, the output
// register holds its word and the sequencer holds on its next emitting
// step. Reset puts the cursor at column 0 and empties the output register;
// the line store needs no clearing, as only written entries are ever read.
module terminal_line_editor_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tle_pkg::BYTE_W-1:0]   key_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [2:0]                   action,
    output logic [tle_pkg::BYTE_W-1:0]   echo_byte,
    output logic                         last_of_run
);

    tle_pkg::status_t st;
    tle_pkg::ctrl_t ctrl;
    logic adv;
    logic last;
    logic accept;

    assign accept = in_valid && in_ready;

    // Step counter and microcode table.
    tle_sequencer u_seq (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .key_byte(key_byte),
        .st(st),
        .in_ready(in_ready),
        .ctrl(ctrl),
        .adv(adv),
        .last(last)
    );

    // Cursor, line store and output register.
    tle_datapath u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .accept(accept),
        .key_byte(key_byte),
        .ctrl(ctrl),
        .adv(adv),
        .last(last),
        .out_ready(out_ready),
        .st(st),
        .out_valid(out_valid),
        .action(action),
        .echo_byte(echo_byte),
        .last_of_run(last_of_run)
    );

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the terminal line editor unit.
`timescale 1ns / 1ps

module tb;
    import tle_pkg::*;

    localparam int RANDOM_KEYS = 460;
    localparam int QUIET_KEYS = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER_WORDS = 150;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 120;

    // One display word as it leaves the block.
    typedef struct packed {
        act_t act;
        logic [BYTE_W-1:0] ch;
        logic last;
    } disp_word_t;

    // One keystroke of the directed part; typed rows carry their single word.
    typedef struct {
        logic [BYTE_W-1:0] k;
        bit typed;
        act_t act;
        logic [BYTE_W-1:0] ch;
    } key_row_t;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [BYTE_W-1:0] key_byte = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] action;
    logic [BYTE_W-1:0] echo_byte;
    logic last_of_run;

    // Line editor state mirrored by the testbench.
    logic [BYTE_W-1:0] line_buf [0:63];
    logic [CUR_W-1:0] col = '0;

    disp_word_t step_words[$];
    disp_word_t expected_words[$];

    int keys_sent = 0;
    int words_checked = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int n_newline = 0;
    int n_erase = 0;
    int n_eof = 0;
    int n_bell = 0;
    bit quiet = 1'b0;
    bit held = 1'b0;

    terminal_line_editor_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .key_byte(key_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .action(action),
        .echo_byte(echo_byte),
        .last_of_run(last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Appends one display word to the words of the current keystroke.
    task automatic put_word(input act_t a, input logic [BYTE_W-1:0] c);
        disp_word_t w;
        w.act = a;
        w.ch = c;
        w.last = 1'b0;
        step_words.push_back(w);
    endtask

    // Removes the character before the cursor and gives one erase word.
    task automatic rub_char();
        col = col - 1'b1;
        put_word(ACT_ERASE, '0);
    endtask

    // Applies one keystroke to the mirrored line and builds its words.
    task automatic edit_line(input logic [BYTE_W-1:0] k);
        disp_word_t w;
        step_words.delete();
        if (k == KEY_EOF && col == 0)
        begin
            put_word(ACT_EOF, '0);
        end
        else if (k == KEY_ERASE)
        begin
            if (col != 0)
                rub_char();
            else
                put_word(ACT_BELL, '0);
        end
        else if (k == KEY_KILL)
        begin
            while (col != 0)
                rub_char();
        end
        else if (k == KEY_WORD)
        begin
            // Trailing spaces go first, then the word in front of them.
            while (col != 0 && line_buf[col - 1] == KEY_SPACE)
                rub_char();
            while (col != 0 && line_buf[col - 1] != KEY_SPACE)
                rub_char();
        end
        else if (k >= PRINT_LOW && k <= PRINT_HIGH)
        begin
            line_buf[col] = k;
            col = col + 1'b1;
            put_word(ACT_ECHO, k);
            if (col == LINE_LENGTH)
            begin
                put_word(ACT_NEWLINE, '0);
                col = '0;
            end
        end
        else
        begin
            put_word(ACT_BELL, '0);
        end
        if (step_words.size() > 0)
        begin
            w = step_words.pop_back();
            w.last = 1'b1;
            step_words.push_back(w);
        end
    endtask

    // Offers one keystroke, waits for it to be taken and records its words.
    task automatic offer_key(input logic [BYTE_W-1:0] k, input bit typed,
                             input act_t a, input logic [BYTE_W-1:0] c);
        disp_word_t w;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        key_byte <= k;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        keys_sent++;
        edit_line(k);
        if (typed)
        begin
            w.act = a;
            w.ch = c;
            w.last = 1'b1;
            expected_words.push_back(w);
        end
        else
        begin
            foreach (step_words[i])
                expected_words.push_back(step_words[i]);
        end
    endtask

    // Printable text, with a space about one time in five.
    function automatic logic [BYTE_W-1:0] text_char();
        if ($urandom_range(0, 4) == 0)
            return KEY_SPACE;
        return BYTE_W'($urandom_range(33, 126));
    endfunction

    // Stimulus: reset, directed keystrokes, then random editing sessions.
    initial
    begin
        key_row_t rows[$];
        int n;
        rows.push_back(key_row_t'{KEY_ERASE, 1'b1, ACT_BELL, 8'd0});
        rows.push_back(key_row_t'{KEY_KILL, 1'b0, ACT_ECHO, 8'd0});
        rows.push_back(key_row_t'{KEY_WORD, 1'b0, ACT_ECHO, 8'd0});
        rows.push_back(key_row_t'{KEY_EOF, 1'b1, ACT_EOF, 8'd0});
        rows.push_back(key_row_t'{8'd0, 1'b1, ACT_BELL, 8'd0});
        rows.push_back(key_row_t'{8'd255, 1'b1, ACT_BELL, 8'd0});
        rows.push_back(key_row_t'{8'd128, 1'b1, ACT_BELL, 8'd0});
        rows.push_back(key_row_t'{8'd31, 1'b1, ACT_BELL, 8'd0});
        rows.push_back(key_row_t'{PRINT_LOW, 1'b1, ACT_ECHO, PRINT_LOW});
        rows.push_back(key_row_t'{PRINT_HIGH, 1'b1, ACT_ECHO, PRINT_HIGH});
        rows.push_back(key_row_t'{KEY_EOF, 1'b1, ACT_BELL, 8'd0});
        rows.push_back(key_row_t'{8'h61, 1'b1, ACT_ECHO, 8'h61});
        rows.push_back(key_row_t'{KEY_SPACE, 1'b1, ACT_ECHO, KEY_SPACE});
        rows.push_back(key_row_t'{8'h62, 1'b0, ACT_ECHO, 8'd0});
        rows.push_back(key_row_t'{KEY_SPACE, 1'b0, ACT_ECHO, 8'd0});
        rows.push_back(key_row_t'{KEY_SPACE, 1'b0, ACT_ECHO, 8'd0});
        rows.push_back(key_row_t'{KEY_WORD, 1'b0, ACT_ECHO, 8'd0});
        rows.push_back(key_row_t'{KEY_ERASE, 1'b1, ACT_ERASE, 8'd0});
        rows.push_back(key_row_t'{KEY_WORD, 1'b0, ACT_ECHO, 8'd0});
        rows.push_back(key_row_t'{KEY_KILL, 1'b0, ACT_ECHO, 8'd0});
        rows.push_back(key_row_t'{8'h7A, 1'b1, ACT_ECHO, 8'h7A});
        rows.push_back(key_row_t'{KEY_WORD, 1'b0, ACT_ECHO, 8'd0});
        rows.push_back(key_row_t'{8'd1, 1'b1, ACT_BELL, 8'd0});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            offer_key(rows[i].k, rows[i].typed, rows[i].act, rows[i].ch);

        // Random sessions: mostly text with edits, some noise and full lines.
        while (keys_sent < rows.size() + RANDOM_KEYS)
        begin
            if (keys_sent >= rows.size() + RANDOM_KEYS - QUIET_KEYS)
                quiet = 1'b1;
            case ($urandom_range(0, 10))
                0, 1, 2, 3, 4, 5:
                begin
                    n = $urandom_range(1, 12);
                    repeat (n) offer_key(text_char(), 1'b0, ACT_ECHO, '0);
                end
                6: offer_key(KEY_ERASE, 1'b0, ACT_ECHO, '0);
                7: offer_key(KEY_KILL, 1'b0, ACT_ECHO, '0);
                8: offer_key(KEY_WORD, 1'b0, ACT_ECHO, '0);
                9:
                begin
                    case ($urandom_range(0, 3))
                        0: offer_key(KEY_EOF, 1'b0, ACT_ECHO, '0);
                        1: offer_key(BYTE_W'($urandom_range(0, 31)), 1'b0, ACT_ECHO, '0);
                        2: offer_key(BYTE_W'($urandom_range(128, 255)), 1'b0, ACT_ECHO, '0);
                        default: offer_key(BYTE_W'($urandom_range(0, 255)), 1'b0,
                                           ACT_ECHO, '0);
                    endcase
                end
                default:
                begin
                    // Run the line to its end and a little beyond.
                    n = LINE_LENGTH - int'(col) + $urandom_range(0, 8);
                    repeat (n) offer_key(text_char(), 1'b0, ACT_ECHO, '0);
                end
            endcase
        end
        in_valid <= 1'b0;

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_words.size() != 0)
        begin
            $display("%d display words never arrived", expected_words.size());
            mismatches++;
        end
        $display("Sent %0d keystrokes; checked %0d display words.", keys_sent, words_checked);
        $display("Seen %0d erase, %0d newline, %0d end-of-input and %0d bell words.",
                 n_erase, n_newline, n_eof, n_bell);
        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off, steady in the last part.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (!held && words_checked >= HOLD_AFTER_WORDS)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // Compare each accepted word with the oldest expected word.
    always @(posedge clk)
    begin
        disp_word_t w;
        if (out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: action %0d byte %0d last %0b",
                             action, echo_byte, last_of_run);
            end
            else
            begin
                w = expected_words.pop_front();
                words_checked++;
                case (w.act)
                    ACT_ERASE: n_erase++;
                    ACT_NEWLINE: n_newline++;
                    ACT_EOF: n_eof++;
                    ACT_BELL: n_bell++;
                    default: ;
                endcase
                if (action !== w.act || echo_byte !== w.ch || last_of_run !== w.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d: expected action %0d byte %0d last %0b, got %0d %0d %0b",
                                 words_checked, w.act, w.ch, w.last,
                                 action, echo_byte, last_of_run);
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves a word.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: errors");
            $finish;
        end
    end

endmodule
